// ===== src/bsma_pkg.sv =====
// Package for the byte stack with multi-byte access.
// Holds the field widths, the operation codes and the status codes.
// No dependencies.
package bsma_pkg;

    localparam int OP_W     = 2;
    localparam int COUNT_W  = 3;
    localparam int ADDR_W   = 10;
    localparam int VALUE_W  = 32;
    localparam int LEVEL_W  = 11;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd2;
    localparam logic [OP_W-1:0] OP_READ  = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd2;

endpackage

// ===== src/byte_stack_multibyte_access.sv =====
// Top level of the byte-addressed stack with big-endian multi-byte access.
// Depends on bsma_pkg (codes and widths) and bsma_ram (the byte store).
//
// Usage notes:
// A command beat is taken at a rising edge where start is high and busy is
// low. It carries operation, byte_count, address and write_value. Every
// command gives exactly one result beat: done is high for one cycle and
// read_value, status and stack_level are valid in that cycle. The receiver
// cannot hold results off, and the block never needs it to.
// The store has one port, so one byte moves per cycle and an access of n
// bytes is serialized through a shift register that moves a byte at a time.
// Push and write-at raise the result strobe after the last byte write; pop
// and read-at add one last state for the registered RAM read. A failing
// access or a zero byte count raises it in the cycle after acceptance. busy
// drops in the cycle of the strobe, so a new command can be taken there;
// one command is in flight at a time.
// After reset the block clears the byte store, one byte per cycle, from
// address 0 up to DEPTH-1, while busy stays high; capacity writes are taken
// at any time. Reset sets the stack pointer to zero and capacity to 1024.
module byte_stack_multibyte_access #(
    parameter int DEPTH     = 1024,
    parameter int MAX_BYTES = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [bsma_pkg::OP_W-1:0]       operation,
    input  logic [bsma_pkg::COUNT_W-1:0]    byte_count,
    input  logic [bsma_pkg::ADDR_W-1:0]     address,
    input  logic [bsma_pkg::VALUE_W-1:0]    write_value,
    input  logic                            cfg_we,
    input  logic [bsma_pkg::LEVEL_W-1:0]    cfg_wdata,
    output logic                            done,
    output logic [bsma_pkg::VALUE_W-1:0]    read_value,
    output logic [bsma_pkg::STATUS_W-1:0]   status,
    output logic [bsma_pkg::LEVEL_W-1:0]    stack_level
);

    localparam int AW        = $clog2(DEPTH);
    // Largest capacity the 11-bit register can express within the store.
    localparam int CAP_LIMIT = (DEPTH > 2047) ? 2047 : DEPTH;
    // Byte addresses and end points are worked out one bit wider than the
    // level so that a sum past the capacity never wraps.
    localparam int PW        = bsma_pkg::LEVEL_W + 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_RLAST
    } state_t;

    state_t                              state_reg, state_next;
    logic [AW-1:0]                       clr_reg, clr_next;
    logic [bsma_pkg::LEVEL_W-1:0]        cap_reg, cap_next;
    logic [bsma_pkg::LEVEL_W-1:0]        sp_reg, sp_next;
    logic [PW-1:0]                       addr_reg, addr_next;
    logic [bsma_pkg::COUNT_W-1:0]        cnt_reg, cnt_next;
    logic [bsma_pkg::VALUE_W-1:0]        sreg_reg, sreg_next;
    logic [bsma_pkg::VALUE_W-1:0]        acc_reg, acc_next;
    logic [bsma_pkg::STATUS_W-1:0]       status_reg, status_next;
    logic                                done_reg, done_next;
    logic                                capv_reg, capv_next;

    logic                                ram_we;
    logic [AW-1:0]                       ram_addr;
    logic [7:0]                          ram_wdata;
    logic [7:0]                          ram_rdata;

    logic [bsma_pkg::COUNT_W-1:0]        n_sat;
    logic [bsma_pkg::LEVEL_W-1:0]        cap_eff;
    logic [PW-1:0]                       cap_w;
    logic [PW-1:0]                       sp_w;
    logic [PW-1:0]                       n_w;
    logic [PW-1:0]                       push_end;
    logic [PW-1:0]                       at_end;
    logic                                accept;

    bsma_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Access size saturates at MAX_BYTES.
    assign n_sat = ({1'b0, byte_count} > (bsma_pkg::COUNT_W + 1)'(MAX_BYTES))
                   ? bsma_pkg::COUNT_W'(MAX_BYTES) : byte_count;

    assign cap_eff  = (cap_reg > bsma_pkg::LEVEL_W'(CAP_LIMIT))
                      ? bsma_pkg::LEVEL_W'(CAP_LIMIT) : cap_reg;
    assign cap_w    = {1'b0, cap_eff};
    assign sp_w     = {1'b0, sp_reg};
    assign n_w      = PW'(n_sat);
    assign push_end = sp_w + n_w;
    assign at_end   = PW'(address) + n_w;
    assign accept   = start && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        cap_next    = cfg_we ? cfg_wdata : cap_reg;
        sp_next     = sp_reg;
        addr_next   = addr_reg;
        cnt_next    = cnt_reg;
        sreg_next   = sreg_reg;
        acc_next    = acc_reg;
        status_next = status_reg;
        done_next   = 1'b0;
        capv_next   = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = AW'(addr_reg);
        ram_wdata   = sreg_reg[7:0];

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = 8'd0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next    = n_sat - 1'b1;
                    sreg_next   = write_value;
                    acc_next    = '0;
                    status_next = bsma_pkg::STAT_OK;
                    case (operation)
                        bsma_pkg::OP_PUSH:
                        begin
                            addr_next = push_end - 1'b1;
                            if (push_end > cap_w)
                            begin
                                status_next = bsma_pkg::STAT_OVERFLOW;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                sp_next = push_end[bsma_pkg::LEVEL_W-1:0];
                                if (n_sat == '0)
                                begin
                                    done_next = 1'b1;
                                end
                                else
                                begin
                                    state_next = ST_WRITE;
                                end
                            end
                        end

                        bsma_pkg::OP_POP:
                        begin
                            addr_next = sp_w - n_w;
                            if (n_w > sp_w)
                            begin
                                status_next = bsma_pkg::STAT_UNDERFLOW;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                sp_next = sp_reg - bsma_pkg::LEVEL_W'(n_sat);
                                if (n_sat == '0)
                                begin
                                    done_next = 1'b1;
                                end
                                else
                                begin
                                    state_next = ST_READ;
                                end
                            end
                        end

                        bsma_pkg::OP_WRITE:
                        begin
                            addr_next = at_end - 1'b1;
                            if (at_end > cap_w)
                            begin
                                status_next = bsma_pkg::STAT_OVERFLOW;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                if (at_end > sp_w)
                                begin
                                    sp_next = at_end[bsma_pkg::LEVEL_W-1:0];
                                end
                                if (n_sat == '0)
                                begin
                                    done_next = 1'b1;
                                end
                                else
                                begin
                                    state_next = ST_WRITE;
                                end
                            end
                        end

                        default:
                        begin
                            // Read at address: underflow takes precedence.
                            addr_next = PW'(address);
                            if (n_w > sp_w)
                            begin
                                status_next = bsma_pkg::STAT_UNDERFLOW;
                                done_next   = 1'b1;
                            end
                            else if (at_end > cap_w)
                            begin
                                status_next = bsma_pkg::STAT_OVERFLOW;
                                done_next   = 1'b1;
                            end
                            else if (n_sat == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_READ;
                            end
                        end
                    endcase
                end
            end

            ST_WRITE:
            begin
                // Bytes go out least significant first, at descending
                // addresses, so the first address ends up most significant.
                ram_we    = 1'b1;
                sreg_next = {8'd0, sreg_reg[bsma_pkg::VALUE_W-1:8]};
                addr_next = addr_reg - 1'b1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end

            ST_READ:
            begin
                // Addresses ascend; each byte returns in the following cycle.
                capv_next = 1'b1;
                addr_next = addr_reg + 1'b1;
                cnt_next  = cnt_reg - 1'b1;
                if (capv_reg)
                begin
                    acc_next = {acc_reg[bsma_pkg::VALUE_W-9:0], ram_rdata};
                end
                if (cnt_reg == '0)
                begin
                    state_next = ST_RLAST;
                end
            end

            ST_RLAST:
            begin
                acc_next   = {acc_reg[bsma_pkg::VALUE_W-9:0], ram_rdata};
                state_next = ST_IDLE;
                done_next  = 1'b1;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            cap_reg    <= bsma_pkg::LEVEL_W'(1024);
            sp_reg     <= '0;
            addr_reg   <= '0;
            cnt_reg    <= '0;
            sreg_reg   <= '0;
            acc_reg    <= '0;
            status_reg <= bsma_pkg::STAT_OK;
            done_reg   <= 1'b0;
            capv_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            cap_reg    <= cap_next;
            sp_reg     <= sp_next;
            addr_reg   <= addr_next;
            cnt_reg    <= cnt_next;
            sreg_reg   <= sreg_next;
            acc_reg    <= acc_next;
            status_reg <= status_next;
            done_reg   <= done_next;
            capv_reg   <= capv_next;
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign read_value  = acc_reg;
    assign status      = status_reg;
    assign stack_level = sp_reg;

`ifndef NO_ASSERTIONS
    // The clearing pass writes zeros and nothing else.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (ram_we && ram_wdata == 8'd0))
        else $error("clearing pass does not write zero");

    // The store is never written while a read is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ || state_reg == ST_RLAST) |-> !ram_we)
        else $error("store written during a read");

    // A successful push advances the pointer by the byte count, saturated at MAX_BYTES.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == bsma_pkg::OP_PUSH && !(push_end > cap_w))
        |=> (sp_reg == $past(push_end[bsma_pkg::LEVEL_W-1:0])))
        else $error("push did not advance the pointer");

    // A failing access returns a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != bsma_pkg::STAT_OK) |-> (read_value == '0))
        else $error("error result carries data");
`endif

endmodule

// ===== src/bsma_ram.sv =====
// Generic single-port RAM with a registered read port.
// Width and depth are parameters. No dependencies.
module bsma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule
